>>> hw/rtl/ssta_pkg.sv
// Shared types and codes for the sorted sparse term accumulator.
`timescale 1ns / 1ps

package ssta_pkg;

  localparam int COEF_W = 32;
  localparam int EXP_W  = 8;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;
  localparam int SCL_W  = 8;
  localparam int CNT_W  = 6;
  localparam int PROD_W = COEF_W + SCL_W;

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SCALE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] ST_MERGED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE     = 2'd3;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic signed [EXP_W-1:0]  expo;
  } term_t;

endpackage

>>> hw/rtl/sorted_sparse_term_accumulator.sv
// Sorted sparse term accumulator: term table in one RAM and its command sequencer.
`timescale 1ns / 1ps

// Holds up to MAX_TERMS polynomial terms sorted by ascending exponent in a single
// synchronous RAM (one write, one read per cycle, read data registered). Issue a
// command with start while busy is low; results appear on out_* for one cycle each,
// marked by out_valid, and cannot be held off. Clear and unknown commands answer
// without leaving idle. Scale and read out walk the table one entry per cycle (an
// empty table is answered from idle), read out giving one result per term. Add and
// subtract scan upward for the exponent one entry per cycle and merge into an equal
// exponent, or, if the table is not full, move the entries above the insertion point
// up one by one and write the new term. The RAM is not cleared after reset; only
// entries below the term count are ever used.
module sorted_sparse_term_accumulator #(
  parameter int MAX_TERMS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [ssta_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [ssta_pkg::COEF_W-1:0]   in_coefficient,
  input  logic signed [ssta_pkg::EXP_W-1:0]    in_exponent,
  input  logic signed [ssta_pkg::SCL_W-1:0]    in_scale_factor,
  output logic                                 out_valid,
  output logic [ssta_pkg::STAT_W-1:0]          out_status,
  output logic [ssta_pkg::CNT_W-1:0]           out_term_count,
  output logic signed [ssta_pkg::COEF_W-1:0]   out_coefficient,
  output logic signed [ssta_pkg::EXP_W-1:0]    out_exponent,
  output logic                                 out_last
);

  localparam int IDX_W = $clog2(MAX_TERMS);
  localparam int HLD_W = $clog2(MAX_TERMS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SHIFT,
    S_INS,
    S_SCALE,
    S_READ
  } state_t;

  state_t                               state_r, state_nxt;
  logic [HLD_W-1:0]                     held_r, held_nxt;
  logic [IDX_W-1:0]                     chk_r, chk_nxt;
  logic [IDX_W-1:0]                     pos_r, pos_nxt;
  logic                                 sub_r;
  logic signed [ssta_pkg::COEF_W-1:0]   coef_r;
  logic signed [ssta_pkg::EXP_W-1:0]    expo_r;
  logic signed [ssta_pkg::SCL_W-1:0]    scale_r;

  logic                                 out_valid_r, out_valid_nxt;
  logic [ssta_pkg::STAT_W-1:0]          out_status_r, out_status_nxt;
  logic [ssta_pkg::CNT_W-1:0]           out_count_r;
  logic signed [ssta_pkg::COEF_W-1:0]   out_coef_r, out_coef_nxt;
  logic signed [ssta_pkg::EXP_W-1:0]    out_expo_r, out_expo_nxt;
  logic                                 out_last_r, out_last_nxt;

  ssta_pkg::term_t                      mem [MAX_TERMS];
  ssta_pkg::term_t                      rd_data_r;
  ssta_pkg::term_t                      wr_data;
  logic [IDX_W-1:0]                     rd_addr;
  logic [IDX_W-1:0]                     wr_addr;
  logic                                 we;

  logic                                 accept;
  logic [IDX_W-1:0]                     last_idx;
  logic                                 chk_last;
  logic                                 full;
  logic signed [ssta_pkg::COEF_W:0]     sum;
  logic signed [ssta_pkg::COEF_W-1:0]   sum_sat;
  logic signed [ssta_pkg::PROD_W-1:0]   prod;
  logic signed [ssta_pkg::COEF_W-1:0]   prod_sat;
  logic signed [ssta_pkg::COEF_W-1:0]   ins_coef;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign last_idx = IDX_W'(held_r - HLD_W'(1));
  assign chk_last = (chk_r == last_idx);
  assign full     = (held_r == HLD_W'(MAX_TERMS));

  // Saturating merge and scale datapaths on the entry just read, and a saturating negate of the new coefficient.
  always_comb begin
    if (sub_r) begin
      sum = (ssta_pkg::COEF_W+1)'(rd_data_r.coef) - (ssta_pkg::COEF_W+1)'(coef_r);
    end else begin
      sum = (ssta_pkg::COEF_W+1)'(rd_data_r.coef) + (ssta_pkg::COEF_W+1)'(coef_r);
    end
    if (sum[ssta_pkg::COEF_W] != sum[ssta_pkg::COEF_W-1]) begin
      sum_sat = sum[ssta_pkg::COEF_W] ? ssta_pkg::COEF_MIN : ssta_pkg::COEF_MAX;
    end else begin
      sum_sat = sum[ssta_pkg::COEF_W-1:0];
    end

    prod = ssta_pkg::PROD_W'(rd_data_r.coef) * ssta_pkg::PROD_W'(scale_r);
    if (prod[ssta_pkg::PROD_W-1:ssta_pkg::COEF_W-1] == '0 ||
        prod[ssta_pkg::PROD_W-1:ssta_pkg::COEF_W-1] == '1) begin
      prod_sat = prod[ssta_pkg::COEF_W-1:0];
    end else begin
      prod_sat = prod[ssta_pkg::PROD_W-1] ? ssta_pkg::COEF_MIN : ssta_pkg::COEF_MAX;
    end

    if (!sub_r) begin
      ins_coef = coef_r;
    end else if (coef_r == ssta_pkg::COEF_MIN) begin
      ins_coef = ssta_pkg::COEF_MAX;
    end else begin
      ins_coef = -coef_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    chk_nxt        = chk_r;
    pos_nxt        = pos_r;
    rd_addr        = '0;
    we             = 1'b0;
    wr_addr        = chk_r;
    wr_data        = rd_data_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = ssta_pkg::ST_DONE;
    out_coef_nxt   = '0;
    out_expo_nxt   = '0;
    out_last_nxt   = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          chk_nxt = '0;
          case (in_cmd)
            ssta_pkg::CMD_ADD, ssta_pkg::CMD_SUB: begin
              if (held_r == '0) begin
                pos_nxt   = '0;
                state_nxt = S_INS;
              end else begin
                state_nxt = S_SRCH;
              end
            end
            ssta_pkg::CMD_SCALE: begin
              if (held_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_SCALE;
              end
            end
            ssta_pkg::CMD_READ: begin
              if (held_r == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end
            ssta_pkg::CMD_CLEAR: begin
              held_nxt      = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SRCH: begin
        if (rd_data_r.expo == expo_r) begin
          we             = 1'b1;
          wr_data.coef   = sum_sat;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ssta_pkg::ST_MERGED;
          state_nxt      = S_IDLE;
        end else if (rd_data_r.expo > expo_r || chk_last) begin
          if (full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ssta_pkg::ST_FULL;
            state_nxt      = S_IDLE;
          end else if (rd_data_r.expo > expo_r) begin
            // open a slot at chk_r: move the top entry first
            pos_nxt   = chk_r;
            chk_nxt   = last_idx;
            rd_addr   = last_idx;
            state_nxt = S_SHIFT;
          end else begin
            pos_nxt   = IDX_W'(held_r);
            state_nxt = S_INS;
          end
        end else begin
          chk_nxt = IDX_W'(chk_r + 1'b1);
          rd_addr = IDX_W'(chk_r + 1'b1);
        end
      end

      S_SHIFT: begin
        we      = 1'b1;
        wr_addr = IDX_W'(chk_r + 1'b1);
        if (chk_r == pos_r) begin
          state_nxt = S_INS;
        end else begin
          chk_nxt = IDX_W'(chk_r - 1'b1);
          rd_addr = IDX_W'(chk_r - 1'b1);
        end
      end

      S_INS: begin
        we             = 1'b1;
        wr_addr        = pos_r;
        wr_data.coef   = ins_coef;
        wr_data.expo   = expo_r;
        held_nxt       = HLD_W'(held_r + 1'b1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = ssta_pkg::ST_INSERTED;
        state_nxt      = S_IDLE;
      end

      S_SCALE: begin
        we           = 1'b1;
        wr_data.coef = prod_sat;
        if (chk_last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          chk_nxt = IDX_W'(chk_r + 1'b1);
          rd_addr = IDX_W'(chk_r + 1'b1);
        end
      end

      S_READ: begin
        out_valid_nxt = 1'b1;
        out_coef_nxt  = rd_data_r.coef;
        out_expo_nxt  = rd_data_r.expo;
        out_last_nxt  = chk_last;
        if (chk_last) begin
          state_nxt = S_IDLE;
        end else begin
          chk_nxt = IDX_W'(chk_r + 1'b1);
          rd_addr = IDX_W'(chk_r + 1'b1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Term RAM, read before write; a same-entry read and write in one cycle only
  // happens where the read data is not used.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    chk_r        <= chk_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= ssta_pkg::CNT_W'(held_nxt);
    out_coef_r   <= out_coef_nxt;
    out_expo_r   <= out_expo_nxt;
    out_last_r   <= out_last_nxt;
    if (accept) begin
      sub_r   <= (in_cmd == ssta_pkg::CMD_SUB);
      coef_r  <= in_coefficient;
      expo_r  <= in_exponent;
      scale_r <= in_scale_factor;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_term_count  = out_count_r;
  assign out_coefficient = out_coef_r;
  assign out_exponent    = out_expo_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HLD_W'(MAX_TERMS))
    else $error("term count above table size");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy || out_valid)
    else $error("accepted transaction neither running nor answered");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("final result while sequencer still busy");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ssta_pkg::ST_INSERTED |-> held_r == $past(held_r) + 1'b1)
    else $error("insert without term count increment");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> chk_r >= pos_r)
    else $error("shift source below insertion point");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the sorted sparse term accumulator.
`timescale 1ns / 1ps

module tb;

  localparam int CMD_W  = ssta_pkg::CMD_W;
  localparam int COEF_W = ssta_pkg::COEF_W;
  localparam int EXP_W  = ssta_pkg::EXP_W;
  localparam int SCL_W  = ssta_pkg::SCL_W;
  localparam int STAT_W = ssta_pkg::STAT_W;
  localparam int CNT_W  = ssta_pkg::CNT_W;

  localparam int MAX_TERMS    = 32;
  localparam int RANDOM_ITEMS = 400;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DIR_ROWS     = 25;

  // Codes the block must answer as a no-op.
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct {
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;
    logic signed [COEF_W-1:0] coef;
    logic signed [EXP_W-1:0]  expo;
    logic                     last;
  } term_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [COEF_W-1:0] coef;
    logic signed [EXP_W-1:0]  expo;
    logic signed [SCL_W-1:0]  scale;
    logic                     pinned;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         in_cmd = '0;
  logic signed [COEF_W-1:0] in_coefficient = '0;
  logic signed [EXP_W-1:0]  in_exponent = '0;
  logic signed [SCL_W-1:0]  in_scale_factor = '0;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic [CNT_W-1:0]         out_term_count;
  logic signed [COEF_W-1:0] out_coefficient;
  logic signed [EXP_W-1:0]  out_exponent;
  logic                     out_last;

  // Typed-in status and count for the current transaction, if any.
  bit                pin_valid = 1'b0;
  logic [STAT_W-1:0] pin_status = '0;
  logic [CNT_W-1:0]  pin_count = '0;

  // Shadow copy of the term table.
  logic signed [COEF_W-1:0] tbl_coef [MAX_TERMS];
  logic signed [EXP_W-1:0]  tbl_expo [MAX_TERMS];
  int                       held_count = 0;

  term_result_t predicted_results[$];
  int           accepted_count = 0;
  int           error_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;

  stim_row_t directed_rows [DIR_ROWS] = '{
    '{ssta_pkg::CMD_READ,  32'sh0000_0000, 8'sh00, 8'sh00, 1'b1, ssta_pkg::ST_DONE,     6'd0},
    '{ssta_pkg::CMD_ADD,   32'sh0001_0000, 8'sh00, 8'sh00, 1'b1, ssta_pkg::ST_INSERTED, 6'd1},
    '{ssta_pkg::CMD_ADD,   ssta_pkg::COEF_MAX, 8'sh7F, 8'sh00, 1'b1, ssta_pkg::ST_INSERTED, 6'd2},
    '{ssta_pkg::CMD_ADD,   ssta_pkg::COEF_MIN, 8'sh80, 8'sh00, 1'b1, ssta_pkg::ST_INSERTED, 6'd3},
    '{ssta_pkg::CMD_ADD,   32'sh0000_0001, 8'sh7F, 8'sh00, 1'b1, ssta_pkg::ST_MERGED,   6'd3},
    '{ssta_pkg::CMD_SUB,   ssta_pkg::COEF_MIN, 8'sh05, 8'sh00, 1'b1, ssta_pkg::ST_INSERTED, 6'd4},
    '{ssta_pkg::CMD_SUB,   32'sh0000_0001, 8'sh80, 8'sh00, 1'b1, ssta_pkg::ST_MERGED,   6'd4},
    '{ssta_pkg::CMD_ADD,   32'shFFFF_0000, 8'sh00, 8'sh00, 1'b1, ssta_pkg::ST_MERGED,   6'd4},
    '{ssta_pkg::CMD_SUB,   ssta_pkg::COEF_MAX, 8'sh05, 8'sh00, 1'b1, ssta_pkg::ST_MERGED, 6'd4},
    '{ssta_pkg::CMD_ADD,   32'shFFFF_FFFF, 8'shFF, 8'sh00, 1'b1, ssta_pkg::ST_INSERTED, 6'd5},
    '{ssta_pkg::CMD_READ,  32'sh0000_0000, 8'sh00, 8'sh00, 1'b0, ssta_pkg::ST_DONE,     6'd0},
    '{ssta_pkg::CMD_SCALE, 32'sh0000_0000, 8'sh00, 8'shFF, 1'b1, ssta_pkg::ST_DONE,     6'd5},
    '{ssta_pkg::CMD_READ,  32'sh0000_0000, 8'sh00, 8'sh00, 1'b0, ssta_pkg::ST_DONE,     6'd0},
    '{ssta_pkg::CMD_SCALE, 32'sh0000_0000, 8'sh00, 8'sh7F, 1'b1, ssta_pkg::ST_DONE,     6'd5},
    '{ssta_pkg::CMD_SCALE, 32'sh0000_0000, 8'sh00, 8'sh80, 1'b1, ssta_pkg::ST_DONE,     6'd5},
    '{ssta_pkg::CMD_READ,  32'sh0000_0000, 8'sh00, 8'sh00, 1'b0, ssta_pkg::ST_DONE,     6'd0},
    '{CMD_RSVD5,           ssta_pkg::COEF_MIN, 8'sh11, 8'sh02, 1'b1, ssta_pkg::ST_DONE, 6'd5},
    '{CMD_RSVD6,           ssta_pkg::COEF_MAX, 8'sh22, 8'sh03, 1'b1, ssta_pkg::ST_DONE, 6'd5},
    '{CMD_RSVD7,           32'sh0000_0000, 8'sh33, 8'sh04, 1'b1, ssta_pkg::ST_DONE,     6'd5},
    '{ssta_pkg::CMD_SCALE, 32'sh0000_0000, 8'sh00, 8'sh00, 1'b1, ssta_pkg::ST_DONE,     6'd5},
    '{ssta_pkg::CMD_READ,  32'sh0000_0000, 8'sh00, 8'sh00, 1'b0, ssta_pkg::ST_DONE,     6'd0},
    '{ssta_pkg::CMD_CLEAR, 32'sh0000_0000, 8'sh00, 8'sh00, 1'b1, ssta_pkg::ST_DONE,     6'd0},
    '{ssta_pkg::CMD_READ,  32'sh0000_0000, 8'sh00, 8'sh00, 1'b1, ssta_pkg::ST_DONE,     6'd0},
    '{ssta_pkg::CMD_SUB,   32'sh0000_0000, 8'sh80, 8'sh00, 1'b1, ssta_pkg::ST_INSERTED, 6'd1},
    '{ssta_pkg::CMD_READ,  32'sh0000_0000, 8'sh00, 8'sh00, 1'b0, ssta_pkg::ST_DONE,     6'd0}
  };

  sorted_sparse_term_accumulator #(
    .MAX_TERMS(MAX_TERMS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_coefficient (in_coefficient),
    .in_exponent    (in_exponent),
    .in_scale_factor(in_scale_factor),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_term_count (out_term_count),
    .out_coefficient(out_coefficient),
    .out_exponent   (out_exponent),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic signed [COEF_W-1:0] sat_coef(input longint v);
    if (v > longint'(ssta_pkg::COEF_MAX)) return ssta_pkg::COEF_MAX;
    if (v < longint'(ssta_pkg::COEF_MIN)) return ssta_pkg::COEF_MIN;
    return COEF_W'(v);
  endfunction

  function automatic void push_result(input logic [STAT_W-1:0] st,
                                      input logic signed [COEF_W-1:0] c,
                                      input logic signed [EXP_W-1:0] e,
                                      input logic l);
    term_result_t entry;
    entry = '{st, CNT_W'(held_count), c, e, l};
    predicted_results.insert(predicted_results.size(), entry);
  endfunction

  // Update the shadow table for one transaction and queue what it produces.
  function automatic void predict_terms(input logic [CMD_W-1:0] cmd,
                                        input logic signed [COEF_W-1:0] coef,
                                        input logic signed [EXP_W-1:0] expo,
                                        input logic signed [SCL_W-1:0] scale);
    int pos;
    int k;
    logic [STAT_W-1:0] st;
    case (cmd)
      ssta_pkg::CMD_ADD, ssta_pkg::CMD_SUB: begin
        pos = 0;
        while (pos < held_count && tbl_expo[pos] < expo) pos++;
        if (pos < held_count && tbl_expo[pos] == expo) begin
          // Keep the term even when it merges to zero.
          if (cmd == ssta_pkg::CMD_SUB)
            tbl_coef[pos] = sat_coef(longint'(tbl_coef[pos]) - longint'(coef));
          else
            tbl_coef[pos] = sat_coef(longint'(tbl_coef[pos]) + longint'(coef));
          st = ssta_pkg::ST_MERGED;
        end else if (held_count >= MAX_TERMS) begin
          st = ssta_pkg::ST_FULL;
        end else begin
          for (k = held_count; k > pos; k--) begin
            tbl_coef[k] = tbl_coef[k-1];
            tbl_expo[k] = tbl_expo[k-1];
          end
          tbl_coef[pos] = (cmd == ssta_pkg::CMD_SUB) ? sat_coef(-longint'(coef)) : coef;
          tbl_expo[pos] = expo;
          held_count++;
          st = ssta_pkg::ST_INSERTED;
        end
        push_result(st, '0, '0, 1'b1);
      end
      ssta_pkg::CMD_SCALE: begin
        for (k = 0; k < held_count; k++)
          tbl_coef[k] = sat_coef(longint'(tbl_coef[k]) * longint'(scale));
        push_result(ssta_pkg::ST_DONE, '0, '0, 1'b1);
      end
      ssta_pkg::CMD_READ: begin
        if (held_count == 0)
          push_result(ssta_pkg::ST_DONE, '0, '0, 1'b1);
        for (k = 0; k < held_count; k++)
          push_result(ssta_pkg::ST_DONE, tbl_coef[k], tbl_expo[k], k + 1 == held_count);
      end
      ssta_pkg::CMD_CLEAR: begin
        held_count = 0;
        push_result(ssta_pkg::ST_DONE, '0, '0, 1'b1);
      end
      default: push_result(ssta_pkg::ST_DONE, '0, '0, 1'b1);
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 40)
      $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : check_results
    term_result_t want;
    int first;
    if (rst_n) begin
      if (out_valid) begin
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d count %0d",
                                    out_status, out_term_count));
        end else begin
          want = predicted_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_term_count !== want.count)
            report_mismatch($sformatf("term_count %0d, want %0d",
                                      out_term_count, want.count));
          if (out_coefficient !== want.coef)
            report_mismatch($sformatf("coefficient %h, want %h",
                                      out_coefficient, want.coef));
          if (out_exponent !== want.expo)
            report_mismatch($sformatf("exponent %0d, want %0d", out_exponent, want.expo));
          if (out_last !== want.last)
            report_mismatch($sformatf("last %b, want %b", out_last, want.last));
        end
      end
      if (start && !busy) begin
        first = predicted_results.size();
        predict_terms(in_cmd, in_coefficient, in_exponent, in_scale_factor);
        if (pin_valid) begin
          predicted_results[first].status = pin_status;
          predicted_results[first].count  = pin_count;
        end
        accepted_count++;
      end
    end
  end

  // Drive one transaction, hold until it is taken, then keep the burst going or idle.
  task automatic issue_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [COEF_W-1:0] coef,
                               input logic signed [EXP_W-1:0] expo,
                               input logic signed [SCL_W-1:0] scale,
                               input bit pin = 1'b0,
                               input logic [STAT_W-1:0] pst = ssta_pkg::ST_DONE,
                               input logic [CNT_W-1:0] pcnt = '0);
    int seen;
    int gap;
    seen            = accepted_count;
    in_cmd          = cmd;
    in_coefficient  = coef;
    in_exponent     = expo;
    in_scale_factor = scale;
    pin_valid       = pin;
    pin_status      = pst;
    pin_count       = pcnt;
    start           = 1'b1;
    do @(negedge clk); while (accepted_count == seen);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start           = 1'b0;
      pin_valid       = 1'b0;
      in_cmd          = CMD_W'($urandom);
      in_coefficient  = $urandom;
      in_exponent     = EXP_W'($urandom);
      in_scale_factor = SCL_W'($urandom);
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 45);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_results_drained();
    start     = 1'b0;
    pin_valid = 1'b0;
    while (predicted_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [COEF_W-1:0] rand_coef();
    logic signed [COEF_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: return v >>> $urandom_range(8, 28);
      1: begin
        case ($urandom_range(0, 4))
          0: return ssta_pkg::COEF_MAX;
          1: return ssta_pkg::COEF_MIN;
          2: return 32'sh0000_0000;
          3: return 32'shFFFF_FFFF;
          default: return 32'sh0000_0001;
        endcase
      end
      default: return v;
    endcase
  endfunction

  function automatic logic signed [SCL_W-1:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 8'shFF;
      1: return 8'sh00;
      2: return 8'sh01;
      3: return $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
      default: return SCL_W'($urandom);
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] rand_add_sub();
    return $urandom_range(0, 1) ? ssta_pkg::CMD_SUB : ssta_pkg::CMD_ADD;
  endfunction

  initial begin : stimulus
    int kind;
    int n;
    int span;
    int r;
    logic signed [EXP_W-1:0] base;
    logic [CMD_W-1:0] op;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      issue_command(directed_rows[i].cmd, directed_rows[i].coef, directed_rows[i].expo,
                    directed_rows[i].scale, directed_rows[i].pinned,
                    directed_rows[i].status, directed_rows[i].count);
    wait_results_drained();

    while (accepted_count < DIR_ROWS + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 1) begin
        // Fill the table past its capacity with scattered exponents.
        issue_command(ssta_pkg::CMD_CLEAR, rand_coef(), EXP_W'($urandom), rand_scale());
        n = $urandom_range(33, 40);
        repeat (n)
          issue_command(rand_add_sub(), rand_coef(), EXP_W'($urandom), rand_scale());
        issue_command(ssta_pkg::CMD_READ, rand_coef(), EXP_W'($urandom), rand_scale());
      end else if (kind <= 6) begin
        // Narrow exponent window so that merges are frequent.
        base = EXP_W'($urandom);
        span = $urandom_range(4, 64);
        n    = $urandom_range(5, 30);
        repeat (n) begin
          r = $urandom_range(0, 99);
          if (r < 82)      op = rand_add_sub();
          else if (r < 90) op = ssta_pkg::CMD_SCALE;
          else if (r < 96) op = ssta_pkg::CMD_READ;
          else if (r < 98) op = ssta_pkg::CMD_CLEAR;
          else             op = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
          issue_command(op, rand_coef(), EXP_W'(base + $urandom_range(0, span - 1)),
                        rand_scale());
        end
        issue_command(ssta_pkg::CMD_READ, rand_coef(), EXP_W'($urandom), rand_scale());
      end else if (kind == 7) begin
        repeat ($urandom_range(1, 5))
          issue_command(CMD_W'($urandom), $urandom, EXP_W'($urandom), SCL_W'($urandom));
      end else if (kind == 8) begin
        wait_results_drained();
        issue_command(ssta_pkg::CMD_READ, rand_coef(), EXP_W'($urandom), rand_scale());
      end else begin
        issue_command(ssta_pkg::CMD_SCALE, rand_coef(), EXP_W'($urandom), rand_scale());
        issue_command(ssta_pkg::CMD_READ, rand_coef(), EXP_W'($urandom), rand_scale());
      end
    end

    wait_results_drained();
    // Catch any stray result after the last expected one.
    repeat (2 * MAX_TERMS + 8) @(negedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ssta_pkg.sv
hw/rtl/sorted_sparse_term_accumulator.sv
tb/sv/tb.sv
